// ===== sv/brfo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package brfo_pkg;

  localparam int DEPTH = 1024;
  localparam int PTR_W = 10;
  localparam int CNT_W = 11;
  localparam int LEN_W = 16;

  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // step a ring pointer by one inside the capacity in use
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] s;
    s = {1'b0, p} + CNT_W'(1);
    return (s == cap) ? '0 : s[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/brfo_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/byte_ring_fifo_overwrite.sv =====
// Byte ring FIFO with optional overwrite of the oldest bytes.
// Input channel (in_valid/in_ready) carries one command word: push one byte,
// pop one byte or clear. A push run starts with first_of_burst set and gives
// its length in burst_len (capped at capacity); the run is taken or refused
// on that word; with overwrite set the oldest bytes are dropped to make room.
// Output channel (out_valid/out_ready) returns exactly one result word per
// command: accepted, read_valid, read_byte, fill_level, is_full, is_empty.
// The result appears in the cycle after acceptance. Throughput is one
// command per cycle: pointers and fill count sit in flip-flops and the byte
// store is one 1024 x 8 RAM with a write port and a registered read port; a
// pop reads the RAM in its accept cycle and the data leaves with the result.
// A stalled receiver holds the result register; in_ready drops until the
// result is taken, so nothing is lost or repeated.
// Writing cfg_wdata with cfg_we sets the capacity (0 acts as 1, above 1024
// acts as 1024) and empties the FIFO; write it only while the block is idle.
// Reset (rst, synchronous) empties the FIFO and sets capacity to 1024; no
// clearing pass is needed, the first command may follow at once.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_overwrite
  import brfo_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       cmd,
  input  wire logic [7:0]       data_byte,
  input  wire logic [LEN_W-1:0] burst_len,
  input  wire logic             first_of_burst,
  input  wire logic             overwrite,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  accepted,
  output logic                  read_valid,
  output logic [7:0]            read_byte,
  output logic [CNT_W-1:0]      fill_level,
  output logic                  is_full,
  output logic                  is_empty,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] cap_cfg;
  logic [CNT_W-1:0] cap_eff;
  logic [PTR_W-1:0] read_ptr, read_ptr_next;
  logic [PTR_W-1:0] write_ptr, write_ptr_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic             run_accepted, run_accepted_next;
  logic [LEN_W-1:0] run_bytes_left, run_bytes_left_next;

  logic             in_fire;
  logic             acc_c, rv_c, ram_we, ram_re;
  logic [CNT_W-1:0] run_len, avail, drop;
  logic [CNT_W:0]   rp_sum;
  logic [7:0]       ram_rdata;

  assign cap_eff  = (cap_cfg == '0) ? CNT_W'(1) : ((cap_cfg > CAP_MAX) ? CAP_MAX : cap_cfg);
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    read_ptr_next       = read_ptr;
    write_ptr_next      = write_ptr;
    fill_count_next     = fill_count;
    run_accepted_next   = run_accepted;
    run_bytes_left_next = run_bytes_left;
    acc_c   = 1'b0;
    rv_c    = 1'b0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    run_len = '0;
    avail   = '0;
    drop    = '0;
    rp_sum  = '0;
    if (in_fire) begin
      case (cmd)
        CMD_PUSH: begin
          if (first_of_burst) begin
            run_len = (burst_len > LEN_W'(cap_eff)) ? cap_eff : burst_len[CNT_W-1:0];
            avail   = (fill_count < cap_eff) ? (cap_eff - fill_count) : '0;
            run_bytes_left_next = LEN_W'(run_len);
            run_accepted_next   = 1'b0;
            if (run_len != '0) begin
              if (run_len <= avail) begin
                run_accepted_next = 1'b1;
              end else if (overwrite) begin
                // drop the oldest bytes now to make room for the whole run
                drop = run_len - avail;
                if (drop > fill_count) begin
                  drop = fill_count;
                end
                rp_sum = {2'b00, read_ptr} + {1'b0, drop};
                if (rp_sum >= {1'b0, cap_eff}) begin
                  rp_sum = rp_sum - {1'b0, cap_eff};
                end
                read_ptr_next     = rp_sum[PTR_W-1:0];
                fill_count_next   = fill_count - drop;
                run_accepted_next = 1'b1;
              end
            end
          end
          if (run_bytes_left_next != '0) begin
            run_bytes_left_next = run_bytes_left_next - LEN_W'(1);
            if (run_accepted_next && (fill_count_next < cap_eff)) begin
              ram_we          = 1'b1;
              write_ptr_next  = ptr_inc(write_ptr, cap_eff);
              fill_count_next = fill_count_next + CNT_W'(1);
              acc_c           = 1'b1;
            end
          end
        end
        CMD_POP: begin
          if (fill_count != '0) begin
            ram_re          = 1'b1;
            rv_c            = 1'b1;
            read_ptr_next   = ptr_inc(read_ptr, cap_eff);
            fill_count_next = fill_count - CNT_W'(1);
            if (fill_count_next == '0) begin
              read_ptr_next  = '0;
              write_ptr_next = '0;
            end
          end
        end
        CMD_CLEAR: begin
          read_ptr_next       = '0;
          write_ptr_next      = '0;
          fill_count_next     = '0;
          run_accepted_next   = 1'b0;
          run_bytes_left_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_cfg        <= CAP_MAX;
      read_ptr       <= '0;
      write_ptr      <= '0;
      fill_count     <= '0;
      run_accepted   <= 1'b0;
      run_bytes_left <= '0;
    end else if (cfg_we) begin
      cap_cfg        <= cfg_wdata;
      read_ptr       <= '0;
      write_ptr      <= '0;
      fill_count     <= '0;
      run_accepted   <= 1'b0;
      run_bytes_left <= '0;
    end else begin
      read_ptr       <= read_ptr_next;
      write_ptr      <= write_ptr_next;
      fill_count     <= fill_count_next;
      run_accepted   <= run_accepted_next;
      run_bytes_left <= run_bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result word; the popped byte comes straight from the RAM read register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      accepted   <= acc_c;
      read_valid <= rv_c;
      fill_level <= fill_count_next;
      is_full    <= (fill_count_next == cap_eff);
      is_empty   <= (fill_count_next == '0);
    end
  end

  assign read_byte = read_valid ? ram_rdata : 8'd0;

  brfo_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (read_ptr),
    .rdata (ram_rdata)
  );

`ifndef ASSERT_OFF
  a_fill_in_cap: assert property (@(posedge clk) disable iff (rst)
    fill_count <= cap_eff)
    else $error("fill count above capacity");

  a_ptr_in_cap: assert property (@(posedge clk) disable iff (rst)
    (read_ptr < cap_eff) && (write_ptr < cap_eff))
    else $error("pointer outside capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill_count == '0) |-> (read_ptr == write_ptr))
    else $error("empty FIFO with split pointers");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && read_valid))
    else $error("result both stored and popped");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import brfo_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int RANDOM_WORDS = 650;

  typedef struct packed {
    logic             accepted;
    logic             read_valid;
    logic [7:0]       read_byte;
    logic [CNT_W-1:0] fill_level;
    logic             is_full;
    logic             is_empty;
  } fifo_status_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       cmd = CMD_NOP;
  logic [7:0]       data_byte = '0;
  logic [LEN_W-1:0] burst_len = '0;
  logic             first_of_burst = 1'b0;
  logic             overwrite = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             accepted;
  logic             read_valid;
  logic [7:0]       read_byte;
  logic [CNT_W-1:0] fill_level;
  logic             is_full;
  logic             is_empty;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  byte_ring_fifo_overwrite i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .data_byte      (data_byte),
    .burst_len      (burst_len),
    .first_of_burst (first_of_burst),
    .overwrite      (overwrite),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .read_valid     (read_valid),
    .read_byte      (read_byte),
    .fill_level     (fill_level),
    .is_full        (is_full),
    .is_empty       (is_empty),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // mirror of the FIFO contents and run state
  logic [7:0]       ring_mem [DEPTH];
  int unsigned      rd_at, wr_at, held, run_left;
  bit               run_open;
  logic [CNT_W-1:0] cap_reg = CAP_MAX;

  fifo_status_t status_due [$];
  int           fail_count = 0;
  int           words_sent = 0;
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;

  function automatic int unsigned usable_slots(input logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > CAP_MAX) return DEPTH;
    return {21'd0, v};
  endfunction

  function automatic void empty_mirror();
    rd_at = 0;
    wr_at = 0;
    held = 0;
    run_left = 0;
    run_open = 1'b0;
  endfunction

  function automatic fifo_status_t predict_status(input logic [1:0] c, input logic [7:0] d,
                                                  input logic [LEN_W-1:0] bl,
                                                  input logic fb, input logic ow);
    fifo_status_t s;
    int unsigned lim, len, room, drop;
    lim = usable_slots(cap_reg);
    s = '0;
    if (c == CMD_PUSH) begin
      if (fb) begin
        len = (bl > lim) ? lim : bl;
        room = (held < lim) ? lim - held : 0;
        run_left = len;
        run_open = 1'b0;
        if (len != 0) begin
          if (len <= room) begin
            run_open = 1'b1;
          end else if (ow) begin
            // drop the oldest bytes right away to make room for the whole run
            drop = len - room;
            if (drop > held) drop = held;
            rd_at = (rd_at + drop) % lim;
            held -= drop;
            run_open = 1'b1;
          end
        end
      end
      if (run_left != 0) begin
        run_left--;
        if (run_open && held < lim) begin
          ring_mem[wr_at] = d;
          wr_at = (wr_at + 1) % lim;
          held++;
          s.accepted = 1'b1;
        end
      end
    end else if (c == CMD_POP) begin
      if (held != 0) begin
        s.read_byte = ring_mem[rd_at];
        s.read_valid = 1'b1;
        rd_at = (rd_at + 1) % lim;
        held--;
        if (held == 0) begin
          rd_at = 0;
          wr_at = 0;
        end
      end
    end else if (c == CMD_CLEAR) begin
      empty_mirror();
    end
    s.fill_level = held[CNT_W-1:0];
    s.is_full = (held == lim);
    s.is_empty = (held == 0);
    return s;
  endfunction

  function automatic void compare_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_result
    fifo_status_t want;
    if (!rst && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        fail_count++;
      end else begin
        want = status_due.pop_front();
        compare_field("accepted", int'(want.accepted), int'(accepted));
        compare_field("read_valid", int'(want.read_valid), int'(read_valid));
        compare_field("read_byte", int'(want.read_byte), int'(read_byte));
        compare_field("fill_level", int'(want.fill_level), int'(fill_level));
        compare_field("is_full", int'(want.is_full), int'(is_full));
        compare_field("is_empty", int'(want.is_empty), int'(is_empty));
      end
    end
  end

  // receiver: stall for a random gap before taking each result, unless rx_steady is set
  initial begin : result_sink
    int gap;
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 10);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // returns at the accepting edge; valid stays up until the next call decides
  task automatic send_word(input logic [1:0] c, input logic [7:0] d,
                           input logic [LEN_W-1:0] bl, input logic fb, input logic ow);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= c;
    data_byte <= d;
    burst_len <= bl;
    first_of_burst <= fb;
    overwrite <= ow;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    status_due.push_back(predict_status(c, d, bl, fb, ow));
    if (c != CMD_NOP) words_sent++;
  endtask

  // first word carries the run length; later words carry junk in the ignored fields
  task automatic push_run(input int unsigned len, input logic ow, input int unsigned n);
    int unsigned i;
    for (i = 0; i < ((n == 0) ? 1 : n); i++) begin
      if (i == 0) send_word(CMD_PUSH, 8'($urandom_range(0, 255)), len[LEN_W-1:0], 1'b1, ow);
      else send_word(CMD_PUSH, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                     1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic pop_bytes(input int unsigned n);
    repeat (n) send_word(CMD_POP, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_reg = v;
    empty_mirror();
  endtask

  task automatic test_empty_fifo();
    pop_bytes(1);
    send_word(CMD_NOP, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
    send_word(CMD_CLEAR, 8'h00, 16'h0000, 1'b0, 1'b0);
    push_run(1, 1'b0, 1);
    pop_bytes(1);
  endtask

  task automatic test_run_rules();
    set_capacity(11'd3);
    push_run(0, 1'b0, 1);
    send_word(CMD_PUSH, 8'hFF, 16'h0001, 1'b0, 1'b1);
    // length far above capacity: store three, refuse the fourth
    push_run(16'hFFFF, 1'b0, 4);
    push_run(2, 1'b0, 1);
    // new run starts while the refused one still has a byte left
    push_run(2, 1'b1, 2);
    pop_bytes(4);
  endtask

  task automatic test_capacity_limits();
    set_capacity('0);
    push_run(1, 1'b0, 1);
    push_run(1, 1'b1, 1);
    pop_bytes(1);
    set_capacity(11'h7FF);
    push_run(2, 1'b0, 2);
    pop_bytes(1);
  endtask

  task automatic test_random_traffic();
    int unsigned goal, pick, lim, len, n, step;
    logic [CNT_W-1:0] capv;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) capv = CNT_W'($urandom_range(1, 12));
      else if (pick < 8) capv = CNT_W'($urandom_range(13, 64));
      else if (pick == 8) capv = CAP_MAX;
      else capv = CNT_W'($urandom_range(0, 2047));
      set_capacity(capv);
      lim = usable_slots(capv);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (step = 0; step < 30 && words_sent < goal; step++) begin
        // hold off until every result is back
        if (step == 15) drain();
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
          len = $urandom_range(1, (lim < 16) ? lim + 1 : 16);
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
          push_run(len, 1'($urandom_range(0, 1)), n);
        end else if (pick < 16) begin
          pop_bytes($urandom_range(1, 6));
        end else if (pick == 16) begin
          send_word(CMD_CLEAR, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick == 17) begin
          send_word(CMD_NOP, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick == 18) begin
          send_word(CMD_PUSH, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    1'b0, 1'($urandom_range(0, 1)));
        end else begin
          len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 65535);
          push_run(len, 1'($urandom_range(0, 1)), $urandom_range(1, 4));
        end
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    empty_mirror();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_empty_fifo();
    test_run_rules();
    test_capacity_limits();
    test_random_traffic();
    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("byte_ring_fifo_overwrite: match");
    end else begin
      $display("byte_ring_fifo_overwrite: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("byte_ring_fifo_overwrite: mismatch");
    $finish;
  end

endmodule
